// ===== src/lfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Long FIR convolver package
// Shared constants, opcode codes and the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package lfc_pkg;

    // Default sizing of the coefficient store and the history ring.
    localparam int MAX_TAPS_DEF  = 4096;
    localparam int COEF_FRAC_DEF = 15;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int INDEX_W    = 12;
    localparam int TAPCNT_W   = 13;
    localparam int PROD_W     = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    // Field positions within the input tdata word.
    localparam int COEF_INDEX_LSB = 0;
    localparam int COEF_VALUE_LSB = 12;
    localparam int SAMPLE_IN_LSB  = 28;

    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 13'd4096;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_FILTER = 1'b1
    } opcode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // write one coefficient
        logic start;   // take a sample and begin a convolution
        logic issue;   // read one tap pair
        logic round;   // scale the finished sum
        logic emit;    // saturate and load the output register
    } lfc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_tap;   // the tap being read is the final one
        logic pipe_busy;  // products are still on their way to the accumulator
        logic out_free;   // the output register can take a new result
    } lfc_sts_t;

endpackage
`default_nettype wire

// ===== src/lfc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== src/lfc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Long FIR convolver controller
// Takes coefficient loads straight from idle and sequences each sample request
// through the tap walk, pipeline drain, scaling and output hand-off.
// ----------------------------------------------------------------------------
module lfc_ctrl
    import lfc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    input  wire logic     s_opcode,
    output logic          s_tready,
    input  wire lfc_sts_t sts,
    output lfc_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (opcode_t'(s_opcode) == OP_FILTER) begin
                        cmd.start  = 1'b1;
                        state_next = ST_RUN;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (sts.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

// ===== src/lfc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Long FIR convolver datapath
// Coefficient and history memories, the shared multiply-accumulate pipeline,
// scaling, saturation and the output register.
// ----------------------------------------------------------------------------
module lfc_datapath
    import lfc_pkg::*;
#(
    parameter int MAX_TAPS       = MAX_TAPS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [TAPCNT_W-1:0]   cfg_wr_data,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    input  wire lfc_cmd_t              cmd,
    output lfc_sts_t                   sts,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + AW;
    localparam logic [AW-1:0] PTR_LAST   = AW'(MAX_TAPS - 1);
    localparam logic [TW-1:0] FILL_FULL  = TW'(MAX_TAPS);
    localparam logic [31:0]   MAX_TAPS_U = 32'(MAX_TAPS);

    // Input fields.
    logic [INDEX_W-1:0]  s_coef_index;
    logic [COEF_W-1:0]   s_coef_value;
    logic [SAMPLE_W-1:0] s_sample_in;

    assign s_coef_index = s_tdata[COEF_INDEX_LSB +: INDEX_W];
    assign s_coef_value = s_tdata[COEF_VALUE_LSB +: COEF_W];
    assign s_sample_in  = s_tdata[SAMPLE_IN_LSB +: SAMPLE_W];

    // Tap count register.
    logic [TAPCNT_W-1:0] tap_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_COUNT_RST;
        end else if (cfg_wr_en) begin
            tap_count_reg <= cfg_wr_data;
        end
    end

    // A tap count of zero means one tap; a count beyond the store means all of it.
    logic [TAPCNT_W-1:0] tap_count_m1;
    logic [AW-1:0]       taps_last;

    assign tap_count_m1 = tap_count_reg - TAPCNT_W'(1);

    always_comb begin
        if (tap_count_reg == '0) begin
            taps_last = '0;
        end else if (32'(tap_count_reg) > MAX_TAPS_U) begin
            taps_last = PTR_LAST;
        end else begin
            taps_last = AW'(tap_count_m1);
        end
    end

    // Walk registers.
    logic [AW-1:0] ptr_reg,    ptr_next;
    logic [TW-1:0] fill_reg,   fill_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] k_reg,      k_next;
    logic [AW-1:0] taps_last_reg;
    logic          last_reg;

    always_comb begin
        ptr_next    = ptr_reg;
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        k_next      = k_reg;
        if (cmd.start) begin
            ptr_next    = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + AW'(1);
            fill_next   = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + TW'(1);
            rd_ptr_next = ptr_reg;
            k_next      = '0;
        end else if (cmd.issue) begin
            rd_ptr_next = (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - AW'(1);
            k_next      = k_reg + AW'(1);
        end else if (cmd.emit && last_reg) begin
            // End of buffer: the ring starts again empty.
            ptr_next  = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end else begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
        k_reg      <= k_next;
        if (cmd.start) begin
            taps_last_reg <= taps_last;
            last_reg      <= s_tlast;
        end
    end

    // Memories.
    logic          coef_wr_en;
    logic [AW-1:0] coef_wr_addr;
    logic [COEF_W-1:0]   coef_rd;
    logic [SAMPLE_W-1:0] hist_rd;

    assign coef_wr_en   = cmd.load && (32'(s_coef_index) < MAX_TAPS_U);
    assign coef_wr_addr = AW'(s_coef_index);

    lfc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (coef_wr_en),
        .wr_addr (coef_wr_addr),
        .wr_data (s_coef_value),
        .rd_addr (k_reg),
        .rd_data (coef_rd)
    );

    lfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (cmd.start),
        .wr_addr (ptr_reg),
        .wr_data (s_sample_in),
        .rd_addr (rd_ptr_reg),
        .rd_data (hist_rd)
    );

    // Multiply-accumulate pipeline. History slots not written since the ring
    // was last emptied count as zero.
    logic                     v1_reg, v2_reg;
    logic                     ok1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic        [SAMPLE_W-1:0] hist_op;

    assign hist_op = ok1_reg ? hist_rd : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ok1_reg  <= (TW'(k_reg) < fill_reg);
        prod_reg <= $signed(coef_rd) * $signed(hist_op);
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // Scaling: magnitude shifted right, which truncates toward zero.
    logic             neg_reg;
    logic [ACC_W-1:0] mag_reg;
    logic [ACC_W-1:0] acc_abs;

    assign acc_abs = acc_reg[ACC_W-1] ? (ACC_W'(0) - ACC_W'(acc_reg)) : ACC_W'(acc_reg);

    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_abs >> COEF_FRAC_BITS;
        end
    end

    // Saturation.
    logic [M_TDATA_W-1:0] q_val;
    logic                 q_clip;

    always_comb begin
        if (neg_reg) begin
            q_clip = (mag_reg > ACC_W'(32768));
            q_val  = q_clip ? 16'h8000 : (16'h0000 - mag_reg[M_TDATA_W-1:0]);
        end else begin
            q_clip = (mag_reg > ACC_W'(32767));
            q_val  = q_clip ? 16'h7fff : mag_reg[M_TDATA_W-1:0];
        end
    end

    // Output register.
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_clip_reg;
    logic                 m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= q_val;
            m_clip_reg <= q_clip;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_clip_reg;
    assign m_tlast  = m_last_reg;

    assign sts.last_tap  = (k_reg == taps_last_reg);
    assign sts.pipe_busy = v1_reg || v2_reg;
    assign sts.out_free  = !m_valid_reg || m_tready;

endmodule
`default_nettype wire

// ===== src/long_fir_convolver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Long FIR convolver
// Coefficient load requests are taken back to back.
// A sample request holds the core until its result is loaded into the output
// register, so no other request is taken meanwhile; the single
// multiply-accumulate reads one coefficient and one history word per cycle
// from the two memories.
// Reset sets the tap count to 4096 and empties the history ring at once.
// ----------------------------------------------------------------------------
module long_fir_convolver
    import lfc_pkg::*;
#(
    parameter int MAX_TAPS       = MAX_TAPS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration: tap_count.
    input  wire logic                  cfg_wr_en,
    input  wire logic [TAPCNT_W-1:0]   cfg_wr_data,
    // Input requests.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // coef_index [11:0], coef_value [27:12], sample_in [43:28], zero [47:44]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  wire logic                  s_tuser,
    input  wire logic                  s_tlast,
    // Result requests.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // sample_out [15:0]
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // clipped
    output logic                       m_tuser,
    output logic                       m_tlast
);

    // The controller only ever steps the datapath through one request at a
    // time. Coefficient loads are written straight into the coefficient
    // memory in the cycle they are accepted. A sample request writes the new
    // sample into the history ring, then the tap walk reads coefficient k and
    // the sample k places older on each cycle, with the products summed in a
    // wide accumulator that cannot overflow for any tap count.
    //
    // The history ring is never swept clean. A count of samples written since
    // the ring was last emptied marks which slots hold real history; older
    // slots are read as zero. At the end of a buffer (tlast on a sample) the
    // count and the write pointer return to zero.
    //
    // The result register sits between the core and the output channel, so
    // further requests are accepted while a result waits to be taken.

    lfc_cmd_t cmd;
    lfc_sts_t sts;

    lfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfc_datapath #(
        .MAX_TAPS       (MAX_TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

// ===== src/lfc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Long FIR convolver checker
// Port-level properties of the convolver, bound to the top level.
// ----------------------------------------------------------------------------
module lfc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // A clipped result is one of the two rails.
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
        else $error("clip flag set on a value that is not a rail");

    // A sample request occupies the core, so the next cycle takes nothing.
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("request accepted during a convolution");

    // Reset leaves no result pending.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind long_fir_convolver lfc_checker u_lfc_checker (.*);
`default_nettype wire
